// ----- hw/rtl/rpq_pkg.sv -----
// ----------------------------------------------------------------------------
// rpq_pkg
// Shared types and constants for the receive packet queue.
// ----------------------------------------------------------------------------
package rpq_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PLEN_W  = 7;
  localparam int unsigned EVICT_W = 8;

  localparam logic [EVICT_W-1:0] EVICT_SAT = '1;
  localparam logic [PLEN_W-1:0]  PLEN_SAT  = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RADIO = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_ABORT = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STORED    = 3'd0,
    KIND_CRC_DROP  = 3'd1,
    KIND_BAD_LEN   = 3'd2,
    KIND_ABORT     = 3'd3,
    KIND_READ_BYTE = 3'd4,
    KIND_EMPTY     = 3'd5,
    KIND_FLUSHED   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_RSSI    = 2'd2,
    PH_LQI     = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT,
    S_EV_CHECK,
    S_EV_WAIT,
    S_PUSH_DATA,
    S_RD_LEN,
    S_RD_ISSUE,
    S_RD_BYTE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LEN,
    OP_STAGE,
    OP_RSSI,
    OP_LQI,
    OP_FLUSH,
    OP_ABORT,
    OP_QRD_HEAD,
    OP_EVICT,
    OP_PUSH_LEN,
    OP_PUSH_BYTE,
    OP_RD_START,
    OP_RD_ISSUE,
    OP_RD_NEXT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   emit;
    kind_e  kind;
    logic   last;
    logic   byte_valid;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e  mode;
    phase_e phase;
    logic   len_bad;
    logic   crc_ok;
    logic   q_empty;
    logic   fits;
    logic   cp_last;
    logic   n_zero;
    logic   rd_last;
    logic   out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/rpq_if.sv -----
// ----------------------------------------------------------------------------
// rpq_if
// Request and result channels of the receive packet queue.
// ----------------------------------------------------------------------------
interface rpq_req_if;
  import rpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] radio_byte;
  logic [BYTE_W-1:0] read_limit;

  modport source (output valid, mode, radio_byte, read_limit, input ready);
  modport sink   (input valid, mode, radio_byte, read_limit, output ready);
endinterface

interface rpq_res_if;
  import rpq_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  data_byte;
  logic               byte_valid;
  logic               last_result;
  logic [EVICT_W-1:0] evicted_packets;
  logic [PLEN_W-1:0]  packet_length;

  modport source (output valid, kind, data_byte, byte_valid, last_result,
                  evicted_packets, packet_length, input ready);
  modport sink   (input valid, kind, data_byte, byte_valid, last_result,
                  evicted_packets, packet_length, output ready);
endinterface

// ----- hw/rtl/rpq_ram.sv -----
// ----------------------------------------------------------------------------
// rpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpq_ctrl
// Sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module rpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  rpq_pkg::dp_status_t status_i,
  output rpq_pkg::ctrl_cmd_t  cmd_o
);
  import rpq_pkg::*;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_STORED;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (status_i.mode)
          MODE_RADIO: begin
            unique case (status_i.phase)
              PH_LEN: begin
                if (status_i.len_bad) begin
                  state_d = S_EMIT;
                  kind_d  = KIND_BAD_LEN;
                end else begin
                  state_d = S_IDLE;
                end
              end
              PH_PAYLOAD, PH_RSSI: state_d = S_IDLE;
              PH_LQI: begin
                if (status_i.crc_ok) begin
                  state_d = S_EV_CHECK;
                end else begin
                  state_d = S_EMIT;
                  kind_d  = KIND_CRC_DROP;
                end
              end
              default: state_d = S_IDLE;
            endcase
          end
          MODE_READ: begin
            if (status_i.q_empty) begin
              state_d = S_EMIT;
              kind_d  = KIND_EMPTY;
            end else begin
              state_d = S_RD_LEN;
            end
          end
          MODE_FLUSH: begin
            state_d = S_EMIT;
            kind_d  = KIND_FLUSHED;
          end
          MODE_ABORT: begin
            state_d = S_EMIT;
            kind_d  = KIND_ABORT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      S_EV_CHECK: begin
        state_d = status_i.fits ? S_PUSH_DATA : S_EV_WAIT;
      end
      S_EV_WAIT: state_d = S_EV_CHECK;
      S_PUSH_DATA: begin
        if (status_i.cp_last) begin
          state_d = S_EMIT;
          kind_d  = KIND_STORED;
        end
      end
      S_RD_LEN: begin
        if (status_i.n_zero) begin
          state_d = S_EMIT;
          kind_d  = KIND_READ_BYTE;
        end else begin
          state_d = S_RD_ISSUE;
        end
      end
      S_RD_ISSUE: state_d = S_RD_BYTE;
      S_RD_BYTE: begin
        if (status_i.out_free) state_d = status_i.rd_last ? S_IDLE : S_RD_ISSUE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready_o      = 1'b0;
    cmd_o            = '0;
    cmd_o.op         = OP_NONE;
    cmd_o.kind       = KIND_STORED;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) cmd_o.op = OP_LATCH;
      end
      S_DECODE: begin
        unique case (status_i.mode)
          MODE_RADIO: begin
            unique case (status_i.phase)
              PH_LEN:     if (!status_i.len_bad) cmd_o.op = OP_LEN;
              PH_PAYLOAD: cmd_o.op = OP_STAGE;
              PH_RSSI:    cmd_o.op = OP_RSSI;
              PH_LQI:     cmd_o.op = OP_LQI;
              default:    cmd_o.op = OP_NONE;
            endcase
          end
          MODE_READ:  if (!status_i.q_empty) cmd_o.op = OP_QRD_HEAD;
          MODE_FLUSH: cmd_o.op = OP_FLUSH;
          MODE_ABORT: cmd_o.op = OP_ABORT;
          default:    cmd_o.op = OP_NONE;
        endcase
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = kind_q;
          cmd_o.last = 1'b1;
        end
      end
      S_EV_CHECK:  cmd_o.op = status_i.fits ? OP_PUSH_LEN : OP_QRD_HEAD;
      S_EV_WAIT:   cmd_o.op = OP_EVICT;
      S_PUSH_DATA: cmd_o.op = OP_PUSH_BYTE;
      S_RD_LEN:    cmd_o.op = OP_RD_START;
      S_RD_ISSUE:  cmd_o.op = OP_RD_ISSUE;
      S_RD_BYTE: begin
        if (status_i.out_free) begin
          cmd_o.op         = OP_RD_NEXT;
          cmd_o.emit       = 1'b1;
          cmd_o.kind       = KIND_READ_BYTE;
          cmd_o.last       = status_i.rd_last;
          cmd_o.byte_valid = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/rpq_dp.sv -----
// ----------------------------------------------------------------------------
// rpq_dp
// Datapath: parser registers, staging RAM, byte ring and result register.
// ----------------------------------------------------------------------------
module rpq_dp #(
  parameter int unsigned MAX_PACKET  = 61,
  parameter int unsigned QUEUE_BYTES = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rpq_pkg::ctrl_cmd_t             cmd_i,
  output rpq_pkg::dp_status_t            status_o,
  input  logic [rpq_pkg::MODE_W-1:0]     mode_i,
  input  logic [rpq_pkg::BYTE_W-1:0]     radio_byte_i,
  input  logic [rpq_pkg::BYTE_W-1:0]     read_limit_i,
  input  logic                           res_ready_i,
  output logic                           res_valid_o,
  output logic [rpq_pkg::KIND_W-1:0]     kind_o,
  output logic [rpq_pkg::BYTE_W-1:0]     data_byte_o,
  output logic                           byte_valid_o,
  output logic                           last_result_o,
  output logic [rpq_pkg::EVICT_W-1:0]    evicted_packets_o,
  output logic [rpq_pkg::PLEN_W-1:0]     packet_length_o
);
  import rpq_pkg::*;

  localparam int unsigned SW   = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam int unsigned QW   = $clog2(QUEUE_BYTES);
  localparam int unsigned FW   = $clog2(QUEUE_BYTES + 1);
  localparam int unsigned SUMW = QW + 1;  // ring depth must be at least 128; the block does not check it

  localparam logic [PLEN_W-1:0] MAX_LEN = PLEN_W'(MAX_PACKET);

  // ring pointer plus a short step, one conditional subtract for the wrap
  function automatic logic [QW-1:0] ring_add(input logic [QW-1:0] ptr,
                                             input logic [PLEN_W-1:0] inc);
    logic [SUMW-1:0] sum;
    sum = SUMW'(ptr) + SUMW'(inc);
    if (sum >= SUMW'(QUEUE_BYTES)) sum = sum - SUMW'(QUEUE_BYTES);
    return sum[QW-1:0];
  endfunction

  // latched request
  mode_e             mode_q;
  logic [BYTE_W-1:0] byte_q, limit_q;

  // parser
  phase_e            phase_q, phase_d;
  logic [PLEN_W-1:0] exp_q, exp_d, cnt_q, cnt_d;

  // ring
  logic [QW-1:0]      head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [EVICT_W-1:0] evict_q, evict_d;
  logic [PLEN_W-1:0]  cp_idx_q, cp_idx_d, len_q, len_d, n_q, n_d, rd_cnt_q, rd_cnt_d;

  // result register
  logic               res_valid_q, res_valid_d;
  kind_e              res_kind_q;
  logic [BYTE_W-1:0]  res_data_q;
  logic               res_bv_q, res_last_q;
  logic [EVICT_W-1:0] res_evict_q;
  logic [PLEN_W-1:0]  res_plen_q;
  logic [PLEN_W-1:0]  plen_new;

  // memories
  logic              st_we, st_re, q_we, q_re;
  logic [SW-1:0]     st_waddr, st_raddr;
  logic [BYTE_W-1:0] st_rdata, q_wdata, q_rdata;
  logic [QW-1:0]     q_waddr, q_raddr;

  logic [PLEN_W-1:0] q_len, step, cp_next, n_calc, n_lim;
  logic [FW:0]       need;
  logic              out_free;

  rpq_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PACKET)) u_stage_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(byte_q),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  rpq_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_BYTES)) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .re_i   (q_re),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  // stored length bytes never exceed MAX_PACKET, so 7 bits hold them
  assign q_len   = q_rdata[PLEN_W-1:0];
  assign step    = q_len + PLEN_W'(1);
  assign cp_next = cp_idx_q + PLEN_W'(1);
  assign n_lim   = (BYTE_W'(q_len) < limit_q) ? q_len : limit_q[PLEN_W-1:0];
  assign n_calc  = (n_lim > MAX_LEN) ? MAX_LEN : n_lim;
  assign need    = (FW+1)'(fill_q) + (FW+1)'(exp_q) + (FW+1)'(1);
  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    status_o.mode     = mode_q;
    status_o.phase    = phase_q;
    status_o.len_bad  = (byte_q == '0) || (byte_q > BYTE_W'(MAX_PACKET));
    status_o.crc_ok   = byte_q[BYTE_W-1];
    status_o.q_empty  = (fill_q == '0);
    status_o.fits     = (need <= (FW+1)'(QUEUE_BYTES));
    status_o.cp_last  = (cp_next == exp_q);
    status_o.n_zero   = (n_calc == '0);
    status_o.rd_last  = (rd_cnt_q + PLEN_W'(1) == n_q);
    status_o.out_free = out_free;
  end

  always_comb begin
    phase_d  = phase_q;
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    evict_d  = evict_q;
    cp_idx_d = cp_idx_q;
    len_d    = len_q;
    n_d      = n_q;
    rd_cnt_d = rd_cnt_q;
    rd_ptr_d = rd_ptr_q;
    st_we    = 1'b0;
    st_waddr = cnt_q[SW-1:0];
    st_re    = 1'b0;
    st_raddr = '0;
    q_we     = 1'b0;
    q_waddr  = tail_q;
    q_wdata  = st_rdata;
    q_re     = 1'b0;
    q_raddr  = head_q;
    unique case (cmd_i.op)
      OP_LEN: begin
        exp_d   = byte_q[PLEN_W-1:0];
        cnt_d   = '0;
        phase_d = PH_PAYLOAD;
      end
      OP_STAGE: begin
        st_we = 1'b1;
        cnt_d = cnt_q + PLEN_W'(1);
        if (cnt_d >= exp_q) phase_d = PH_RSSI;
      end
      OP_RSSI: phase_d = PH_LQI;
      OP_LQI: begin
        phase_d = PH_LEN;
        evict_d = '0;
      end
      OP_FLUSH: begin
        head_d = '0;
        tail_d = '0;
        fill_d = '0;
      end
      OP_ABORT: begin
        phase_d = PH_LEN;
        exp_d   = '0;
        cnt_d   = '0;
      end
      OP_QRD_HEAD: q_re = 1'b1;
      OP_EVICT: begin
        head_d = ring_add(head_q, step);
        fill_d = fill_q - FW'(step);
        if (evict_q != EVICT_SAT) evict_d = evict_q + EVICT_W'(1);
      end
      OP_PUSH_LEN: begin
        q_we     = 1'b1;
        q_wdata  = BYTE_W'(exp_q);
        tail_d   = ring_add(tail_q, PLEN_W'(1));
        fill_d   = fill_q + FW'(1);
        cp_idx_d = '0;
        st_re    = 1'b1;
      end
      OP_PUSH_BYTE: begin
        q_we     = 1'b1;
        tail_d   = ring_add(tail_q, PLEN_W'(1));
        fill_d   = fill_q + FW'(1);
        cp_idx_d = cp_next;
        st_re    = (cp_next != exp_q);
        st_raddr = cp_next[SW-1:0];
      end
      OP_RD_START: begin
        len_d    = q_len;
        n_d      = n_calc;
        rd_cnt_d = '0;
        rd_ptr_d = ring_add(head_q, PLEN_W'(1));
        head_d   = ring_add(head_q, step);
        fill_d   = fill_q - FW'(step);
      end
      OP_RD_ISSUE: begin
        q_re    = 1'b1;
        q_raddr = rd_ptr_q;
      end
      OP_RD_NEXT: begin
        rd_ptr_d = ring_add(rd_ptr_q, PLEN_W'(1));
        rd_cnt_d = rd_cnt_q + PLEN_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd_i.kind) inside
      KIND_STORED, KIND_CRC_DROP: plen_new = exp_q;
      KIND_BAD_LEN:   plen_new = (byte_q > BYTE_W'(PLEN_SAT)) ? PLEN_SAT
                                                              : byte_q[PLEN_W-1:0];
      KIND_READ_BYTE: plen_new = len_q;
      default:        plen_new = '0;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_i.emit) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      exp_q       <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      mode_q  <= mode_e'(mode_i);
      byte_q  <= radio_byte_i;
      limit_q <= read_limit_i;
    end
    evict_q  <= evict_d;
    cp_idx_q <= cp_idx_d;
    len_q    <= len_d;
    n_q      <= n_d;
    rd_cnt_q <= rd_cnt_d;
    rd_ptr_q <= rd_ptr_d;
    if (cmd_i.emit) begin
      res_kind_q  <= cmd_i.kind;
      res_last_q  <= cmd_i.last;
      res_bv_q    <= cmd_i.byte_valid;
      res_data_q  <= cmd_i.byte_valid ? q_rdata : '0;
      res_evict_q <= (cmd_i.kind == KIND_STORED) ? evict_q : '0;
      res_plen_q  <= plen_new;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign kind_o            = res_kind_q;
  assign data_byte_o       = res_data_q;
  assign byte_valid_o      = res_bv_q;
  assign last_result_o     = res_last_q;
  assign evicted_packets_o = res_evict_q;
  assign packet_length_o   = res_plen_q;

endmodule

// ----- hw/rtl/rx_packet_queue_drop_oldest_top.sv -----
// ----------------------------------------------------------------------------
// rx_packet_queue_drop_oldest_top
// Length-prefixed receive packet queue with drop-oldest eviction.
// ----------------------------------------------------------------------------
// A request is taken in S_IDLE and decoded in the next cycle in S_DECODE; a
//   radio byte that ends no packet then returns to S_IDLE, and a single
//   result passes through S_EMIT, which waits for a free output register.
// A store evicts through S_EV_CHECK and S_EV_WAIT, then writes one ring byte
//   per S_PUSH_DATA step; a read of bytes loops S_RD_ISSUE and S_RD_BYTE.
// Reset: parser, head and tail pointers, fill count and output valid clear at once.
module rx_packet_queue_drop_oldest_top #(
  parameter int unsigned MAX_PACKET  = 61,
  parameter int unsigned QUEUE_BYTES = 512
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rpq_req_if.sink  req_i,
  rpq_res_if.source res_o
);
  import rpq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The sequencer owns the request handshake; the datapath latches the
  // request fields when it sees the latch command.
  rpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: parser state, staging RAM, byte ring and the output register
  // that decouples the result side from the request side.
  rpq_dp #(
    .MAX_PACKET (MAX_PACKET),
    .QUEUE_BYTES(QUEUE_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .mode_i           (req_i.mode),
    .radio_byte_i     (req_i.radio_byte),
    .read_limit_i     (req_i.read_limit),
    .res_ready_i      (res_o.ready),
    .res_valid_o      (res_o.valid),
    .kind_o           (res_o.kind),
    .data_byte_o      (res_o.data_byte),
    .byte_valid_o     (res_o.byte_valid),
    .last_result_o    (res_o.last_result),
    .evicted_packets_o(res_o.evicted_packets),
    .packet_length_o  (res_o.packet_length)
  );

endmodule

// ----- hw/rtl/rpq_checker.sv -----
// ----------------------------------------------------------------------------
// rpq_checker
// Port-level checks of the receive packet queue, bound to the top level.
// ----------------------------------------------------------------------------
module rpq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [rpq_pkg::KIND_W-1:0]     kind_i,
  input logic [rpq_pkg::BYTE_W-1:0]     data_byte_i,
  input logic                           byte_valid_i,
  input logic                           last_result_i,
  input logic [rpq_pkg::EVICT_W-1:0]    evicted_packets_i,
  input logic [rpq_pkg::PLEN_W-1:0]     packet_length_i
);
  import rpq_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(kind_i) &&
    $stable(data_byte_i) && $stable(last_result_i) && $stable(packet_length_i))
    else $error("result changed while stalled");

  // one request at a time: no request is taken right after another
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken in back-to-back cycles");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !byte_valid_i |-> data_byte_i == '0)
    else $error("data byte set without byte valid");

  // only read requests give more than one result
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i != KIND_READ_BYTE |-> last_result_i && !byte_valid_i)
    else $error("non-read result not final or carrying a byte");

  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i != KIND_STORED |-> evicted_packets_i == '0)
    else $error("eviction count on a non-store result");

endmodule

bind rx_packet_queue_drop_oldest_top rpq_checker u_rpq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .kind_i           (res_o.kind),
  .data_byte_i      (res_o.data_byte),
  .byte_valid_i     (res_o.byte_valid),
  .last_result_i    (res_o.last_result),
  .evicted_packets_i(res_o.evicted_packets),
  .packet_length_i  (res_o.packet_length)
);
